// ===== hdl/periodic_tick_dispatcher_macros.svh =====
// ----------------------------------------------------------------------------
// Periodic tick dispatcher assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TICK_DISPATCHER_MACROS_SVH
`define PERIODIC_TICK_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic tick dispatcher package
// Field widths, operation and result codes, stream payload layouts and the
// request and response of the shared remainder unit.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SliceW  = 20;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned TotalW  = 5;
  localparam int unsigned KindW   = 3;
  localparam int unsigned OpW     = 2;
  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 192;

  localparam logic [TimeW-1:0]  TimeMax      = '1;
  localparam logic [CountW-1:0] CountMax     = '1;
  // Four milliseconds.
  localparam logic [SliceW-1:0] SliceResetUs = 20'd4000;

  typedef enum logic [OpW-1:0] {
    OP_SCAN = 2'd0,
    OP_ADD  = 2'd1,
    OP_DONE = 2'd2,
    OP_SNAP = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_DISPATCH = 3'd0,
    KIND_SCAN_END = 3'd1,
    KIND_ADD_ACK  = 3'd2,
    KIND_DONE_ACK = 3'd3,
    KIND_STATS    = 3'd4
  } kind_e;

  // Input payload; the last declared field sits in the lowest bits.
  typedef struct packed {
    logic [2:0]         pad;
    logic [CountW-1:0]  run_time_us;
    logic               run_succeeded;
    logic [SlotW-1:0]   done_index;
    logic [PeriodW-1:0] entry_period;
    logic [TimeW-1:0]   current_time;
  } in_data_t;

  // Output payload; the last declared field sits in the lowest bits.
  typedef struct packed {
    logic [5:0]        pad;
    logic [TotalW-1:0] entry_total;
    logic [CountW-1:0] longest_run_us;
    logic [CountW-1:0] error_count;
    logic [CountW-1:0] skipped_count;
    logic [CountW-1:0] executed_count;
    logic [TimeW-1:0]  wake_time;
    logic              rejected;
    logic [SlotW-1:0]  slot_index;
  } out_data_t;

  typedef struct packed {
    logic               start;
    logic [TimeW-1:0]   dividend;
    logic [PeriodW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic               done;
    logic [PeriodW-1:0] rem;
  } rem_rsp_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + CountW'(1);
  endfunction

endpackage

// ===== hdl/ptd_rem_unit.sv =====
// ----------------------------------------------------------------------------
// Periodic tick dispatcher remainder unit
// Restoring shift-subtract remainder of a time difference by a period, one
// dividend bit per cycle, with an early exit when the dividend is smaller.
// ----------------------------------------------------------------------------
module ptd_rem_unit
  import ptd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(TimeW);

  typedef enum logic [1:0] {
    R_IDLE,
    R_LOAD,
    R_RUN,
    R_DONE
  } rstate_e;

  rstate_e            state_q, state_d;
  logic [TimeW-1:0]   dvd_q, dvd_d;
  logic [PeriodW-1:0] dvs_q, dvs_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [PeriodW:0]   trial;
  logic               fits;

  always_comb begin
    trial   = {rem_q, dvd_q[TimeW-1]};
    fits    = trial >= {1'b0, dvs_q};
    state_d = state_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          dvd_d   = req_i.dividend;
          dvs_d   = req_i.divisor;
          state_d = R_LOAD;
        end
      end
      R_LOAD: begin
        // Most entries are less than one period late: no iteration needed.
        if (dvd_q < TimeW'(dvs_q)) begin
          rem_d   = dvd_q[PeriodW-1:0];
          state_d = R_DONE;
        end else begin
          rem_d   = '0;
          step_d  = '0;
          state_d = R_RUN;
        end
      end
      R_RUN: begin
        rem_d  = fits ? PeriodW'(trial - {1'b0, dvs_q}) : trial[PeriodW-1:0];
        dvd_d  = {dvd_q[TimeW-2:0], 1'b0};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(TimeW - 1)) begin
          state_d = R_DONE;
        end
      end
      R_DONE: begin
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      dvd_q   <= '0;
      dvs_q   <= '0;
      rem_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      dvd_q   <= dvd_d;
      dvs_q   <= dvs_d;
      rem_q   <= rem_d;
      step_q  <= step_d;
    end
  end

  assign rsp_o.done = (state_q == R_DONE);
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/periodic_tick_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Periodic tick dispatcher
// Table of periodic entries with catch-up scan, dispatch, skip counting,
// completion bookkeeping and statistics snapshot.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_axis channel (operation in tuser), results
// leave on m_axis (kind in tuser, tlast on the final result of a command).
// One command is worked on at a time; s_axis_tready is high only while the
// sequencer is idle, but a finished result may still wait in the output
// register while the next command is taken.
// Add, completion and snapshot load their single result into the output
// register from their own state once the register is free. A scan walks
// the entries in slot order through one shared remainder unit: an entry
// that is not due is read, checked and folded into the wake time; a due
// entry also passes the remainder unit, which exits early when it is less
// than one period late and else drops missed frames, resolving one dividend
// bit per cycle; an entry skipped because it is still in flight leaves out
// the dispatch state. The scan end is loaded after the last entry.
// When the receiver stalls, the sequencer holds at the next result until the
// output register is free. After reset the table is empty, statistics are
// zero and the wake slice is four milliseconds; cfg_we_i writes the slice.
// ----------------------------------------------------------------------------
`include "periodic_tick_dispatcher_macros.svh"

module periodic_tick_dispatcher
  import ptd_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SliceW-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // current_time, entry_period, done_index, run_succeeded, run_time_us, zeros
  input  logic [InDataW-1:0]   s_axis_tdata,
  // operation
  input  logic [OpW-1:0]       s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // slot_index, rejected, wake_time, executed_count, skipped_count,
  // error_count, longest_run_us, entry_total, zeros
  output logic [OutDataW-1:0]  m_axis_tdata,
  // result_kind
  output logic [KindW-1:0]     m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UsedW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DIV,
    S_UPD,
    S_WAKE,
    S_DISP,
    S_END,
    S_ADD,
    S_CMPL,
    S_SNAP
  } state_e;

  // Entry store
  logic [TimeW-1:0]   fire_mem [MAX_ENTRIES];
  logic [PeriodW-1:0] per_mem  [MAX_ENTRIES];
  logic [TimeW-1:0]   fire_rd_q;
  logic [PeriodW-1:0] per_rd_q;
  logic               fire_we, per_we;
  logic [IdxW-1:0]    wr_addr;
  logic [TimeW-1:0]   wr_fire;
  logic [PeriodW-1:0] wr_per;

  // Sequencer and bookkeeping
  state_e             state_q, state_d;
  in_data_t           in_q, in_d;
  logic [UsedW-1:0]   idx_q, idx_d, idx_nx;
  logic [UsedW-1:0]   used_q, used_d;
  logic [MAX_ENTRIES-1:0] busy_q, busy_d;
  logic [CountW-1:0]  done_q, done_d, skip_q, skip_d, fail_q, fail_d, peak_q, peak_d;
  logic [SliceW-1:0]  slice_q, slice_d;
  logic [TimeW-1:0]   wake_q, wake_d, new_q, new_d;
  logic [TimeW:0]     sum_q, sum_d;
  logic               due_q, due_d;
  logic [TimeW:0]     wake_sum, late, upd;
  logic [IdxW-1:0]    cur, cmpl_idx;
  logic               cmpl_ok, is_full;

  // Output register
  out_data_t          out_q, out_d;
  kind_e              kind_q, kind_d;
  logic               last_q, last_d, ovalid_q, out_load, out_free;

  rem_req_t           rem_req;
  rem_rsp_t           rem_rsp;

  ptd_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (fire_we) begin
      fire_mem[wr_addr] <= wr_fire;
    end
    if (per_we) begin
      per_mem[wr_addr] <= wr_per;
    end
    fire_rd_q <= fire_mem[cur];
    per_rd_q  <= per_mem[cur];
  end

  assign out_free = !ovalid_q || m_axis_tready;
  assign cur      = idx_q[IdxW-1:0];
  assign idx_nx   = idx_q + UsedW'(1);
  assign cmpl_idx = IdxW'(in_q.done_index);
  assign cmpl_ok  = 32'(in_q.done_index) < 32'(used_q);
  assign is_full  = (used_q == UsedW'(MAX_ENTRIES));
  // current_time sits in the lowest bits of the incoming transfer.
  assign wake_sum = {1'b0, s_axis_tdata[TimeW-1:0]} + (TimeW + 1)'(slice_q);
  // The due test and the elapsed time share one subtractor.
  assign late     = {1'b0, in_q.current_time} - {1'b0, fire_rd_q};
  // New fire time is now + period - ((now - fire) mod period).
  assign upd      = sum_q - (TimeW + 1)'(rem_rsp.rem);

  always_comb begin
    state_d  = state_q;
    in_d     = in_q;
    idx_d    = idx_q;
    used_d   = used_q;
    busy_d   = busy_q;
    done_d   = done_q;
    skip_d   = skip_q;
    fail_d   = fail_q;
    peak_d   = peak_q;
    slice_d  = cfg_we_i ? cfg_wdata_i : slice_q;
    wake_d   = wake_q;
    new_d    = new_q;
    sum_d    = sum_q;
    due_d    = due_q;
    fire_we  = 1'b0;
    per_we   = 1'b0;
    wr_addr  = cur;
    wr_fire  = new_d;
    wr_per   = (in_q.entry_period == '0) ? PeriodW'(1) : in_q.entry_period;
    rem_req.start    = 1'b0;
    rem_req.dividend = late[TimeW-1:0];
    rem_req.divisor  = per_rd_q;
    out_load = 1'b0;
    out_d    = '0;
    out_d.entry_total = TotalW'(used_q);
    kind_d   = KIND_DISPATCH;
    last_d   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_d = in_data_t'(s_axis_tdata);
        if (s_axis_tvalid) begin
          unique case (op_e'(s_axis_tuser))
            OP_SCAN: begin
              wake_d  = wake_sum[TimeW] ? TimeMax : wake_sum[TimeW-1:0];
              idx_d   = '0;
              state_d = (used_q == '0) ? S_END : S_RD;
            end
            OP_ADD:  state_d = S_ADD;
            OP_DONE: state_d = S_CMPL;
            OP_SNAP: state_d = S_SNAP;
            default: state_d = S_IDLE;
          endcase
        end else begin
          in_d = in_q;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        due_d = !late[TimeW];
        if (!late[TimeW]) begin
          rem_req.start = 1'b1;
          state_d       = S_DIV;
        end else begin
          new_d   = fire_rd_q;
          state_d = S_WAKE;
        end
      end
      S_DIV: begin
        sum_d = {1'b0, in_q.current_time} + (TimeW + 1)'(per_rd_q);
        if (rem_rsp.done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        new_d   = upd[TimeW] ? TimeMax : upd[TimeW-1:0];
        wr_fire = new_d;
        fire_we = 1'b1;
        state_d = S_WAKE;
      end
      S_WAKE: begin
        if (new_q < wake_q) begin
          wake_d = new_q;
        end
        if (due_q && !busy_q[cur]) begin
          state_d = S_DISP;
        end else begin
          if (due_q) begin
            skip_d = sat_inc(skip_q);
          end
          idx_d   = idx_nx;
          state_d = (idx_nx < used_q) ? S_RD : S_END;
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.slot_index = SlotW'(cur);
          busy_d[cur]      = 1'b1;
          idx_d            = idx_nx;
          state_d          = (idx_nx < used_q) ? S_RD : S_END;
        end
      end
      S_END: begin
        if (out_free) begin
          out_load        = 1'b1;
          kind_d          = KIND_SCAN_END;
          last_d          = 1'b1;
          out_d.wake_time = wake_q;
          state_d         = S_IDLE;
        end
      end
      S_ADD: begin
        wr_addr = used_q[IdxW-1:0];
        wr_fire = in_q.current_time;
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_ADD_ACK;
          last_d   = 1'b1;
          state_d  = S_IDLE;
          if (is_full) begin
            out_d.rejected = 1'b1;
          end else begin
            fire_we                     = 1'b1;
            per_we                      = 1'b1;
            busy_d[used_q[IdxW-1:0]]    = 1'b0;
            used_d                      = used_q + UsedW'(1);
            out_d.slot_index            = SlotW'(used_q);
            out_d.entry_total           = TotalW'(used_q + UsedW'(1));
          end
        end
      end
      S_CMPL: begin
        if (out_free) begin
          out_load         = 1'b1;
          kind_d           = KIND_DONE_ACK;
          last_d           = 1'b1;
          out_d.slot_index = in_q.done_index;
          out_d.rejected   = !cmpl_ok;
          state_d          = S_IDLE;
          if (cmpl_ok) begin
            busy_d[cmpl_idx] = 1'b0;
            done_d           = sat_inc(done_q);
            if (!in_q.run_succeeded) begin
              fail_d = sat_inc(fail_q);
            end
            if (in_q.run_time_us > peak_q) begin
              peak_d = in_q.run_time_us;
            end
          end
        end
      end
      S_SNAP: begin
        if (out_free) begin
          out_load             = 1'b1;
          kind_d               = KIND_STATS;
          last_d               = 1'b1;
          out_d.executed_count = done_q;
          out_d.skipped_count  = skip_q;
          out_d.error_count    = fail_q;
          out_d.longest_run_us = peak_q;
          done_d               = '0;
          skip_d               = '0;
          fail_d               = '0;
          peak_d               = '0;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_q     <= '0;
      idx_q    <= '0;
      used_q   <= '0;
      busy_q   <= '0;
      done_q   <= '0;
      skip_q   <= '0;
      fail_q   <= '0;
      peak_q   <= '0;
      slice_q  <= SliceResetUs;
      wake_q   <= '0;
      new_q    <= '0;
      sum_q    <= '0;
      due_q    <= 1'b0;
      out_q    <= '0;
      kind_q   <= KIND_DISPATCH;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      in_q    <= in_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      skip_q  <= skip_d;
      fail_q  <= fail_d;
      peak_q  <= peak_d;
      slice_q <= slice_d;
      wake_q  <= wake_d;
      new_q   <= new_d;
      sum_q   <= sum_d;
      due_q   <= due_d;
      if (out_load) begin
        out_q    <= out_d;
        kind_q   <= kind_d;
        last_q   <= last_d;
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  `PTD_ASSERT_NOW(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= UsedW'(MAX_ENTRIES), "entry count exceeds table depth")
  `PTD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second command taken while one is in progress")
  `PTD_ASSERT_NOW(a_rem_range, clk_i, rst_ni, rem_rsp.done, rem_rsp.rem < per_rd_q, "remainder not below the period")
  `PTD_ASSERT_NOW(a_dispatch_not_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_DISPATCH), !m_axis_tlast, "dispatch marked as final result of a scan")

endmodule
